>>> src/svn_pkg.sv
// svn_pkg: shared types and fixed constants of the spin vector normalizer
// no dependencies
`default_nettype none

package svn_pkg;

  localparam int FRAC_BITS = 13;              // q2.13 fraction
  localparam int QUOT_BITS = 14;              // quotient magnitude range 0..8192
  localparam int OUT_BITS  = 15;              // signed result width
  localparam logic [OUT_BITS-1:0] ONE_Q13 = 15'sd8192;

  // pipeline control that travels with each stage
  typedef struct packed {
    logic adv;   // whole pipeline moves this cycle
    logic vld;   // stage holds a live item
  } pipe_ctl_t;

endpackage

`default_nettype wire

>>> src/svn_if.sv
// svn_in_if / svn_out_if: valid-ready channels of the spin vector normalizer
// depends on svn_pkg
`default_nettype none

interface svn_in_if #(parameter int COMPONENT_BITS = 16);
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] comp_x;
  logic signed [COMPONENT_BITS-1:0] comp_y;
  logic signed [COMPONENT_BITS-1:0] comp_z;
  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface svn_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [svn_pkg::OUT_BITS-1:0]    norm_x;
  logic signed [svn_pkg::OUT_BITS-1:0]    norm_y;
  logic signed [svn_pkg::OUT_BITS-1:0]    norm_z;
  logic                                   was_zero;
  modport source (output valid, norm_x, norm_y, norm_z, was_zero, input ready);
  modport sink   (input valid, norm_x, norm_y, norm_z, was_zero, output ready);
endinterface

`default_nettype wire

>>> src/spin_vector_normalize.sv
// spin_vector_normalize: top level of the spin vector normalizer
// depends on svn_pkg, svn_if, svn_sqrt, svn_div_lane
`default_nettype none

// Normalizes one signed q2.13 spin vector per transfer. The magnitudes and
// their squares are formed in three parallel lanes, summed, and passed
// through a COMPONENT_BITS-stage square root pipeline that yields
// L = floor(sqrt(x*x+y*y+z*z)). Three divider lanes then compute
// |c|*8192/L, one quotient bit per stage over 14 stages, and a merge stage
// restores signs and substitutes (0,0,1.0) with was_zero set when L is zero.
// One transfer is accepted every cycle while the output is not stalled. The
// whole pipeline shares one advance enable: it moves whenever the output
// register is empty or being taken, so in_chan.ready drops only while a
// result waits at the output.

module spin_vector_normalize #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  svn_in_if.sink    in_chan,
  svn_out_if.source out_chan
);

  localparam int CB = COMPONENT_BITS;
  localparam int OB = svn_pkg::OUT_BITS;
  localparam int QB = svn_pkg::QUOT_BITS;
  localparam int PW = 3 * CB + 3;

  logic adv;
  logic out_valid_r;

  assign adv            = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = adv;

  // sign / magnitude split per lane
  logic [CB-1:0]   raw [3];
  logic [CB-1:0]   mag_r [3];
  logic [2:0]      neg_r;
  logic            a_vld_r;

  assign raw[0] = in_chan.comp_x;
  assign raw[1] = in_chan.comp_y;
  assign raw[2] = in_chan.comp_z;

  // squares, then sum
  logic [2*CB-1:0] sq_r [3];
  logic [CB-1:0]   mag_b_r [3];
  logic [2:0]      neg_b_r;
  logic            b_vld_r;
  logic [2*CB-1:0] sum_r;
  logic [PW-1:0]   pay_c_r;
  logic            c_vld_r;

  for (genvar i = 0; i < 3; i++) begin : g_lane_in
    always_ff @(posedge clk) begin
      if (adv) begin
        neg_r[i]   <= raw[i][CB-1];
        // most negative value maps to 2^(CB-1), still fits unsigned
        mag_r[i]   <= raw[i][CB-1] ? CB'(-raw[i]) : raw[i];
        sq_r[i]    <= (2*CB)'(mag_r[i]) * (2*CB)'(mag_r[i]);
        mag_b_r[i] <= mag_r[i];
        neg_b_r[i] <= neg_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_chan.valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
    if (adv) begin
      // three squares each at most 2^(2CB-2): the sum fits 2CB bits
      sum_r   <= sq_r[0] + sq_r[1] + sq_r[2];
      pay_c_r <= {neg_b_r, mag_b_r[2], mag_b_r[1], mag_b_r[0]};
    end
  end

  // square root pipeline, carries magnitudes and signs along
  svn_pkg::pipe_ctl_t ctl_c, ctl_s;
  logic [CB-1:0] len_s;
  logic [PW-1:0] pay_s;

  assign ctl_c.adv = adv;
  assign ctl_c.vld = c_vld_r;

  svn_sqrt #(.CB(CB), .PW(PW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (ctl_c),
    .rad_in   (sum_r),
    .pay_in   (pay_c_r),
    .ctl_out  (ctl_s),
    .root_out (len_s),
    .pay_out  (pay_s)
  );

  // divider lanes
  svn_pkg::pipe_ctl_t ctl_d [3];
  logic [QB-1:0] quot_d [3];
  logic [2:0]    neg_d;
  logic [2:0]    zero_d;

  for (genvar i = 0; i < 3; i++) begin : g_div
    svn_div_lane #(.CB(CB)) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_in   (ctl_s),
      .mag_in   (pay_s[i*CB +: CB]),
      .neg_in   (pay_s[3*CB + i]),
      .len_in   (len_s),
      .ctl_out  (ctl_d[i]),
      .quot_out (quot_d[i]),
      .neg_out  (neg_d[i]),
      .zero_out (zero_d[i])
    );
  end

  // merge stage: signs back on, zero vector replaced by +z
  logic [OB-1:0] signed_q [3];
  for (genvar i = 0; i < 3; i++) begin : g_sign
    assign signed_q[i] = neg_d[i] ? OB'(-{1'b0, quot_d[i]}) : {1'b0, quot_d[i]};
  end

  logic [OB-1:0] norm_x_r, norm_y_r, norm_z_r;
  logic          was_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_d[0].vld;
    end
    if (adv) begin
      was_zero_r <= zero_d[0];
      norm_x_r   <= zero_d[0] ? '0 : signed_q[0];
      norm_y_r   <= zero_d[0] ? '0 : signed_q[1];
      norm_z_r   <= zero_d[0] ? svn_pkg::ONE_Q13 : signed_q[2];
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.norm_x   = norm_x_r;
  assign out_chan.norm_y   = norm_y_r;
  assign out_chan.norm_z   = norm_z_r;
  assign out_chan.was_zero = was_zero_r;

`ifndef SYNTHESIS
  // zero flag always comes with the +z unit vector
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && was_zero_r |->
      norm_x_r == '0 && norm_y_r == '0 && norm_z_r == svn_pkg::ONE_Q13)
    else $error("zero result not the unit z vector");

  // a waiting result is not lost while the sink stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(norm_x_r)
      && $stable(norm_z_r))
    else $error("stalled result dropped or changed");

  // lanes move in lockstep
  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_d[0].vld == ctl_d[1].vld && ctl_d[1].vld == ctl_d[2].vld)
    else $error("divider lanes out of step");

  // all lanes see the same length, so they agree on the zero case
  a_zero_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_d[0].vld |-> zero_d[0] == zero_d[1] && zero_d[1] == zero_d[2])
    else $error("divider lanes disagree on zero length");

  // input is refused only while a result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_valid_r)
    else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire

>>> src/svn_sqrt.sv
// svn_sqrt: pipelined integer square root, one root bit per stage
// depends on svn_pkg
`default_nettype none

module svn_sqrt #(
  parameter int CB = 16,
  parameter int PW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire svn_pkg::pipe_ctl_t   ctl_in,
  input  wire logic [2*CB-1:0]      rad_in,
  input  wire logic [PW-1:0]        pay_in,
  output      svn_pkg::pipe_ctl_t   ctl_out,
  output      logic [CB-1:0]        root_out,
  output      logic [PW-1:0]        pay_out
);

  localparam int RW = CB + 2;

  logic [RW-1:0]   rem_r  [CB];
  logic [CB-1:0]   root_r [CB];
  logic [2*CB-1:0] rad_r  [CB];
  logic [PW-1:0]   pay_r  [CB];
  logic [CB-1:0]   vld_r;

  for (genvar s = 0; s < CB; s++) begin : g_stage
    logic [RW-1:0]   rem_p;
    logic [CB-1:0]   root_p;
    logic [2*CB-1:0] rad_p;
    logic [PW-1:0]   pay_p;
    logic            vld_p;
    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_in;
      assign pay_p  = pay_in;
      assign vld_p  = ctl_in.vld;
    end else begin : g_rest
      assign rem_p  = rem_r[s-1];
      assign root_p = root_r[s-1];
      assign rad_p  = rad_r[s-1];
      assign pay_p  = pay_r[s-1];
      assign vld_p  = vld_r[s-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_p[RW-3:0], rad_p[2*CB-1 -: 2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (ctl_in.adv) begin
        vld_r[s] <= vld_p;
      end
      if (ctl_in.adv) begin
        rem_r[s]  <= ge ? rem_sh - trial : rem_sh;
        root_r[s] <= {root_p[CB-2:0], ge};
        rad_r[s]  <= {rad_p[2*CB-3:0], 2'b00};
        pay_r[s]  <= pay_p;
      end
    end
  end

  assign ctl_out.adv = ctl_in.adv;
  assign ctl_out.vld = vld_r[CB-1];
  assign root_out    = root_r[CB-1];
  assign pay_out     = pay_r[CB-1];

endmodule

`default_nettype wire

>>> src/svn_div_lane.sv
// svn_div_lane: one component lane, pipelined restoring divide of mag*8192 by len
// depends on svn_pkg
`default_nettype none

module svn_div_lane #(
  parameter int CB = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire svn_pkg::pipe_ctl_t                 ctl_in,
  input  wire logic [CB-1:0]                      mag_in,
  input  wire logic                               neg_in,
  input  wire logic [CB-1:0]                      len_in,
  output      svn_pkg::pipe_ctl_t                 ctl_out,
  output      logic [svn_pkg::QUOT_BITS-1:0]      quot_out,
  output      logic                               neg_out,
  output      logic                               zero_out
);

  localparam int QB = svn_pkg::QUOT_BITS;
  localparam int NW = CB + svn_pkg::FRAC_BITS;

  logic [NW-1:0] rem_r  [QB];
  logic [QB-1:0] quot_r [QB];
  logic [CB-1:0] len_r  [QB];
  logic [QB-1:0] neg_r;
  logic [QB-1:0] vld_r;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NW-1:0] rem_p;
    logic [QB-1:0] quot_p;
    logic [CB-1:0] len_p;
    logic          neg_p;
    logic          vld_p;
    logic [NW-1:0] dsh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p  = {mag_in, {svn_pkg::FRAC_BITS{1'b0}}};
      assign quot_p = '0;
      assign len_p  = len_in;
      assign neg_p  = neg_in;
      assign vld_p  = ctl_in.vld;
    end else begin : g_rest
      assign rem_p  = rem_r[k-1];
      assign quot_p = quot_r[k-1];
      assign len_p  = len_r[k-1];
      assign neg_p  = neg_r[k-1];
      assign vld_p  = vld_r[k-1];
    end

    // divisor aligned to quotient bit QB-1-k
    assign dsh = NW'(len_p) << (QB - 1 - k);
    assign ge  = rem_p >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl_in.adv) begin
        vld_r[k] <= vld_p;
      end
      if (ctl_in.adv) begin
        rem_r[k]  <= ge ? rem_p - dsh : rem_p;
        quot_r[k] <= {quot_p[QB-2:0], ge};
        len_r[k]  <= len_p;
        neg_r[k]  <= neg_p;
      end
    end
  end

  assign ctl_out.adv = ctl_in.adv;
  assign ctl_out.vld = vld_r[QB-1];
  assign quot_out    = quot_r[QB-1];
  assign neg_out     = neg_r[QB-1];
  assign zero_out    = len_r[QB-1] == '0;

endmodule

`default_nettype wire

>>> dv/svn_tb_if.sv
// testbench-side notes: the channel interfaces come from src/svn_if.sv
// depends on svn_pkg; holds the small item types shared by the testbench
`default_nettype none

package svn_tb_pkg;

  // one spin vector as offered on the input channel
  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
  } spin_item_t;

  // one normalized vector as expected on the result channel
  typedef struct packed {
    logic signed [svn_pkg::OUT_BITS-1:0] nx;
    logic signed [svn_pkg::OUT_BITS-1:0] ny;
    logic signed [svn_pkg::OUT_BITS-1:0] nz;
    logic                                zero;
  } unit_vec_t;
endpackage

`default_nettype wire

>>> dv/spin_vector_normalize_tb.sv
// spin_vector_normalize_tb: self-checking bench for the spin vector normalizer
// depends on svn_pkg, svn_tb_pkg, svn_if and spin_vector_normalize
`default_nettype none

module spin_vector_normalize_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = 16 + 18;
  localparam int WDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;

  svn_in_if #(.COMPONENT_BITS(16)) in_chan();
  svn_out_if                       out_chan();

  spin_vector_normalize #(.COMPONENT_BITS(16)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  svn_tb_pkg::spin_item_t spin_queue[$];     // vectors waiting to be offered
  svn_tb_pkg::unit_vec_t  unit_queue[$];     // normalized vectors not yet seen
  int         err_count;
  int         idle_cycles;
  bit         stim_done;
  bit         quiet_phase;       // long stretch with no idling
  int         hold_off;          // receiver hold-off cycles left
  bit         hold_done;

  // floor(sqrt(n)) by bit-pair method
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // expected unit vector for one spin vector
  function automatic svn_tb_pkg::unit_vec_t normalize_spin(svn_tb_pkg::spin_item_t s);
    svn_tb_pkg::unit_vec_t u;
    longint          c[3];
    longint unsigned m[3];
    longint unsigned len, sq;
    longint          q[3];
    c[0] = s.cx;
    c[1] = s.cy;
    c[2] = s.cz;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? -c[i] : c[i];
      sq += m[i] * m[i];
    end
    len = floor_root(sq);
    if (len == 0) begin
      u.nx = '0;
      u.ny = '0;
      u.nz = svn_pkg::ONE_Q13;
      u.zero = 1'b1;
      return u;
    end
    for (int i = 0; i < 3; i++) begin
      q[i] = longint'((m[i] * 64'd8192) / len);
      if (c[i] < 0) q[i] = -q[i];
    end
    u.nx = q[0][svn_pkg::OUT_BITS-1:0];
    u.ny = q[1][svn_pkg::OUT_BITS-1:0];
    u.nz = q[2][svn_pkg::OUT_BITS-1:0];
    u.zero = 1'b0;
    return u;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_count++;
  endtask

  function automatic svn_tb_pkg::spin_item_t mk(int x, int y, int z);
    svn_tb_pkg::spin_item_t s;
    s.cx = x[15:0];
    s.cy = y[15:0];
    s.cz = z[15:0];
    return s;
  endfunction

  // random component: mix of full range, small, zero and extreme values
  function automatic int rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 15) - 8;
      1: return $urandom_range(0, 1) ? -32768 : 32767;
      2: return 0;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stimulus: directed corners first, then random vectors
  initial begin
    rst_n = 1'b0;
    err_count = 0;
    stim_done = 1'b0;
    spin_queue.push_back(mk(0, 0, 0));                   // zero vector
    spin_queue.push_back(mk(1, 0, 0));                   // shortest vectors
    spin_queue.push_back(mk(0, -1, 0));
    spin_queue.push_back(mk(0, 0, 1));
    spin_queue.push_back(mk(1, 1, 1));
    spin_queue.push_back(mk(-1, -1, -1));
    spin_queue.push_back(mk(-32768, 0, 0));              // most negative alone
    spin_queue.push_back(mk(-32768, -32768, -32768));
    spin_queue.push_back(mk(32767, 32767, 32767));
    spin_queue.push_back(mk(32767, -32768, 0));
    spin_queue.push_back(mk(8192, 0, 0));                // unit length
    spin_queue.push_back(mk(0, 8192, 0));
    spin_queue.push_back(mk(0, 0, -8192));
    spin_queue.push_back(mk(3, 4, 0));                   // exact root
    spin_queue.push_back(mk(1, 2, 2));
    spin_queue.push_back(mk(-21845, 21845, -10922));
    spin_queue.push_back(mk(1, 32767, -1));
    for (int i = 0; i < 1050; i++)
      spin_queue.push_back(mk(rand_comp(), rand_comp(), rand_comp()));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: offers the queue head, idles at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid  <= 1'b0;
      in_chan.comp_x <= '0;
      in_chan.comp_y <= '0;
      in_chan.comp_z <= '0;
    end else begin
      bit take;
      take = in_chan.valid && in_chan.ready;
      if (take) begin
        unit_queue.push_back(normalize_spin(spin_queue.pop_front()));
      end
      if ((!in_chan.valid || take) && spin_queue.size() != 0
          && (quiet_phase || $urandom_range(0, 99) >= 27)) begin
        in_chan.valid  <= 1'b1;
        in_chan.comp_x <= spin_queue[0].cx;
        in_chan.comp_y <= spin_queue[0].cy;
        in_chan.comp_z <= spin_queue[0].cz;
      end else if (take) begin
        in_chan.valid <= 1'b0;
      end
      if (take && spin_queue.size() == 0) stim_done <= 1'b1;
    end
  end

  // quiet stretch: mid-run, while the queue drains from 700 to 400 vectors, no idling on either side
  initial begin
    quiet_phase = 1'b0;
    wait (spin_queue.size() < 700 && rst_n);
    quiet_phase = 1'b1;
    wait (spin_queue.size() < 400);
    quiet_phase = 1'b0;
  end

  // receiver hold-off counter, triggered once early in the random part
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && spin_queue.size() < 900) begin
      hold_off  <= 200;
      hold_done <= 1'b1;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor: compares each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (unit_queue.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          svn_tb_pkg::unit_vec_t w;
          w = unit_queue.pop_front();
          if (out_chan.norm_x !== w.nx) report_mismatch("norm_x", out_chan.norm_x, w.nx);
          if (out_chan.norm_y !== w.ny) report_mismatch("norm_y", out_chan.norm_y, w.ny);
          if (out_chan.norm_z !== w.nz) report_mismatch("norm_z", out_chan.norm_z, w.nz);
          if (out_chan.was_zero !== w.zero)
            report_mismatch("was_zero", out_chan.was_zero, w.zero);
        end
      end
      out_chan.ready <= (hold_off == 0) && (quiet_phase || $urandom_range(0, 99) >= 27);
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // end of run
  initial begin
    wait (rst_n);
    fork
      begin
        wait (stim_done && unit_queue.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
      end
      wait (idle_cycles >= WDOG_LIMIT);
    join_any
    if (idle_cycles < WDOG_LIMIT && unit_queue.size() == 0 && err_count == 0)
      $display("spin_vector_normalize regression: pass");
    else
      $display("spin_vector_normalize regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
